// File: rtl/core/agitation_moving_average_detector_macros.svh
// Assertion macros for the agitation detector checker.
// Depends on nothing; the asserting module provides clk_i and rst_ni.
`ifndef AGITATION_MOVING_AVERAGE_DETECTOR_MACROS_SVH
`define AGITATION_MOVING_AVERAGE_DETECTOR_MACROS_SVH

// Same-cycle implication, disabled during reset
`define AMAD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("amad assertion failed");

// Next-cycle implication, disabled during reset
`define AMAD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("amad assertion failed");

`endif

// File: rtl/core/amad_pkg.sv
// Package for the agitation detector: widths, window constants, state codes.
// No dependencies.
package amad_pkg;

  localparam int unsigned AXIS_W   = 16;
  localparam int unsigned MAG_W    = 16;
  localparam int unsigned THR_W    = 16;
  localparam int unsigned WINDOW   = 5;
  localparam int unsigned SUM_W    = 20;
  localparam int unsigned POS_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned RAD_W    = 32;
  localparam int unsigned REM_W    = 17;
  localparam int unsigned CS_W     = 20;
  localparam int unsigned SQRT_STEPS = 16;
  localparam int unsigned CNT_W    = 5;
  localparam logic [15:0] THR_RESET = 16'd1671;

  // Divide by WINDOW as a multiply by the rounded-up reciprocal and a shift;
  // exact for every SUM_W-bit sum
  localparam int unsigned DIV_SHIFT = SUM_W + $clog2(WINDOW);
  localparam int unsigned RCP_W     = SUM_W + 1;
  localparam logic [RCP_W-1:0] DIV_RCP =
    RCP_W'(((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  // Sequencer state codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQX  = 3'd1;
  localparam logic [2:0] ST_SQY  = 3'd2;
  localparam logic [2:0] ST_SQRT = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;
  localparam logic [2:0] ST_DLD  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd7;

  // Ring update request from the sequencer
  typedef struct packed {
    logic             upd;
    logic [MAG_W-1:0] mag;
  } ring_req_t;

endpackage

// File: rtl/core/agitation_moving_average_detector.sv
// Agitation detector top level: squares, iterative square root, window sum, divide.
// Sequence: one word at a time through x and y squaring, 16 square-root steps on the shared unit,
//   ring update, divide and compare; a stalled result holds the input.
// Reset: async active low; ring, sum and position clear, threshold returns to 1671.
// Depends on amad_pkg, amad_cmpsub, amad_ring.
module agitation_moving_average_detector (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [47:0]                  s_axis_tdata_i,  // accel_x, accel_y, accel_z
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [15:0]                  m_axis_tdata_o,  // average_magnitude
  output logic [2:0]                   m_axis_tuser_o,  // alarm, z_negative, z_positive
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [amad_pkg::THR_W-1:0]   cfg_data_i
);
  import amad_pkg::*;

  logic [2:0]             state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic signed [AXIS_W-1:0] x_q, x_d, y_q, y_d;
  logic                   zneg_q, zneg_d, zpos_q, zpos_d;
  logic [RAD_W-1:0]       rad_q, rad_d;
  logic [REM_W-1:0]       rem_q, rem_d;
  logic [MAG_W-1:0]       root_q, root_d;
  logic [MAG_W-1:0]       quo_q, quo_d;
  logic [THR_W-1:0]       thr_q;
  logic                   ovalid_q, ovalid_d;
  logic [MAG_W-1:0]       oavg_q, oavg_d;
  logic [2:0]             ouser_q, ouser_d;

  logic signed [AXIS_W-1:0]   mul_op;
  logic signed [2*AXIS_W-1:0] sq;
  logic [REM_W+1:0]       rem_sh_sqrt;
  logic [SUM_W+RCP_W-1:0] quo_prod;
  logic [CS_W-1:0]        cs_a, cs_b, cs_diff;
  logic                   cs_ge;
  logic                   in_acc, out_free;
  ring_req_t              ring_req;
  logic [SUM_W-1:0]       win_sum;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !ovalid_q || m_axis_tready_i;

  // Single squarer, x then y
  assign mul_op = (state_q == ST_SQX) ? x_q : y_q;
  assign sq     = mul_op * mul_op;

  // Partial remainder shifted in for the next root step
  assign rem_sh_sqrt = {rem_q, rad_q[RAD_W-1 -: 2]};

  // Window sum divided by the window length via reciprocal multiply
  assign quo_prod = win_sum * DIV_RCP;

  // Operand select for the shared unit
  always_comb begin
    case (state_q)
      ST_SQRT: begin
        cs_a = CS_W'(rem_sh_sqrt);
        cs_b = CS_W'({root_q, 2'b01});
      end
      ST_DONE: begin
        cs_a = CS_W'(thr_q);
        cs_b = CS_W'(quo_q);
      end
      default: begin
        cs_a = '0;
        cs_b = '0;
      end
    endcase
  end

  amad_cmpsub u_cmpsub (
    .a_i    (cs_a),
    .b_i    (cs_b),
    .ge_o   (cs_ge),
    .diff_o (cs_diff)
  );

  assign ring_req.upd = (state_q == ST_UPD);
  assign ring_req.mag = root_q;

  amad_ring u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ring_req),
    .sum_o  (win_sum)
  );

  // Sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    x_d      = x_q;
    y_d      = y_q;
    zneg_d   = zneg_q;
    zpos_d   = zpos_q;
    rad_d    = rad_q;
    rem_d    = rem_q;
    root_d   = root_q;
    quo_d    = quo_q;
    ovalid_d = ovalid_q && !m_axis_tready_i;
    oavg_d   = oavg_q;
    ouser_d  = ouser_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          x_d     = s_axis_tdata_i[15:0];
          y_d     = s_axis_tdata_i[31:16];
          zneg_d  = s_axis_tdata_i[47];
          zpos_d  = !s_axis_tdata_i[47] && (|s_axis_tdata_i[46:32]);
          state_d = ST_SQX;
        end
      end
      ST_SQX: begin
        rad_d   = RAD_W'(sq);
        state_d = ST_SQY;
      end
      ST_SQY: begin
        rad_d   = rad_q + RAD_W'(sq);
        rem_d   = '0;
        root_d  = '0;
        cnt_d   = CNT_W'(SQRT_STEPS - 1);
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        // one root bit per step
        rad_d = {rad_q[RAD_W-3:0], 2'b00};
        if (cs_ge) begin
          rem_d  = cs_diff[REM_W-1:0];
          root_d = {root_q[MAG_W-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh_sqrt[REM_W-1:0];
          root_d = {root_q[MAG_W-2:0], 1'b0};
        end
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        state_d = ST_DLD;
      end
      ST_DLD: begin
        // floored average of the updated window
        quo_d   = MAG_W'(quo_prod >> DIV_SHIFT);
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // alarm when threshold < average
        if (out_free) begin
          ovalid_d = 1'b1;
          oavg_d   = quo_q;
          ouser_d  = {zpos_q, zneg_q, !cs_ge};
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
      thr_q    <= THR_RESET;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    zneg_q  <= zneg_d;
    zpos_q  <= zpos_d;
    rad_q   <= rad_d;
    rem_q   <= rem_d;
    root_q  <= root_d;
    quo_q   <= quo_d;
    oavg_q  <= oavg_d;
    ouser_q <= ouser_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = oavg_q;
  assign m_axis_tuser_o  = ouser_q;
  assign cfg_ready_o     = 1'b1;

endmodule

// File: rtl/core/amad_cmpsub.sv
// Shared compare-subtract unit: one step of square root, and the threshold compare.
// Depends on amad_pkg.
module amad_cmpsub (
  input  logic [amad_pkg::CS_W-1:0] a_i,
  input  logic [amad_pkg::CS_W-1:0] b_i,
  output logic                      ge_o,
  output logic [amad_pkg::CS_W-1:0] diff_o
);
  import amad_pkg::*;

  // a >= b and a - b from one subtractor
  logic [CS_W:0] sub;

  assign sub    = {1'b0, a_i} - {1'b0, b_i};
  assign ge_o   = ~sub[CS_W];
  assign diff_o = sub[CS_W-1:0];

endmodule

// File: rtl/core/amad_ring.sv
// Ring of the last WINDOW magnitudes and the running window sum.
// Depends on amad_pkg.
module amad_ring (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  amad_pkg::ring_req_t        req_i,
  output logic [amad_pkg::SUM_W-1:0] sum_o
);
  import amad_pkg::*;

  logic [MAG_W-1:0] ring_q [WINDOW];
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [POS_W-1:0] pos_q, pos_d;

  // Drop the oldest entry, add the new one
  always_comb begin
    sum_d = sum_q - SUM_W'(ring_q[pos_q]) + SUM_W'(req_i.mag);
    pos_d = (pos_q == POS_W'(WINDOW - 1)) ? '0 : pos_q + POS_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      pos_q <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        ring_q[i] <= '0;
      end
    end else if (req_i.upd) begin
      sum_q         <= sum_d;
      pos_q         <= pos_d;
      ring_q[pos_q] <= req_i.mag;
    end
  end

  assign sum_o = sum_q;

endmodule

// File: rtl/core/amad_checker.sv
// Port-level checker for the agitation detector, bound to the top level.
// Depends on agitation_moving_average_detector_macros.svh.
`include "agitation_moving_average_detector_macros.svh"

module amad_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o
);

  // a word in flight blocks the input side
  `AMAD_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)

  // a result only appears after a busy cycle
  `AMAD_ASSERT_NOW(a_result_after_work, $rose(m_axis_tvalid_o), $past(!s_axis_tready_o))

  // z cannot be both below and above zero
  `AMAD_ASSERT_NOW(a_z_flags_exclusive, m_axis_tvalid_o, !(m_axis_tuser_o[1] && m_axis_tuser_o[2]))

  // stalled output word holds
  `AMAD_ASSERT_NXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
                   m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))

endmodule

bind agitation_moving_average_detector amad_checker u_amad_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
